// ----- hw/rtl/ert_pkg.sv -----
// shared constants, payload types and the sine rom contents for the euler point transform
`default_nettype none

package ert_pkg;

	// sine table size (entries 0..SINE_TABLE_DEPTH cover one quarter wave)
	localparam int SINE_TABLE_DEPTH = 1024;

	// angle units are 1/64 degree
	localparam int QUARTER_TURN = 5760;
	localparam int HALF_QUARTER = QUARTER_TURN / 2;
	localparam int HALF_TURN    = 2 * QUARTER_TURN;
	localparam int THREE_QUARTER = 3 * QUARTER_TURN;
	localparam int FULL_TURN    = 4 * QUARTER_TURN;

	// quarter turn is an odd factor times a power of two
	localparam int QUARTER_SHIFT = 7;
	localparam int QUARTER_ODD   = QUARTER_TURN / (1 << QUARTER_SHIFT);

	// reciprocal of the odd factor, exact for all index numerators used here
	localparam logic [31:0] IDX_RECIP =
		32'(((64'd1 << 32) + 64'(QUARTER_ODD) - 64'd1) / 64'(QUARTER_ODD));

	// widths of the angle to table index path
	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int U_W    = $clog2(QUARTER_TURN + 1);
	localparam int NUM_W  = $clog2(QUARTER_TURN * SINE_TABLE_DEPTH + HALF_QUARTER + 1);
	localparam int QDIV_W = NUM_W - QUARTER_SHIFT;
	localparam int PRD_W  = QDIV_W + 32;

	// datapath widths
	localparam int SIN_W  = 15;
	localparam int RED_W  = 15;
	localparam int ANG_W  = 17;
	localparam int ENT_W  = 49;
	localparam int MAT_W  = 33;
	localparam int MUL_W  = 65;
	localparam int SUM_W  = 67;
	localparam int ROW_W  = 37;
	localparam int OUT_W  = 38;

	localparam int NUM_STAGES = 12;
	localparam int NUM_LANES  = 6;

	// pi/2 in Q61
	localparam logic [63:0] HALF_PI_Q61  = 64'h3243F6A8885A308D;
	localparam logic [63:0] HALF_PI_STEP = HALF_PI_Q61 / SINE_TABLE_DEPTH;
	localparam logic [63:0] HALF_PI_REM  = HALF_PI_Q61 % SINE_TABLE_DEPTH;

	typedef logic [SIN_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [15:0] angle_about_x;
		logic signed [15:0] angle_about_y;
		logic signed [15:0] angle_about_z;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_x;
		logic signed [31:0] result_y;
		logic signed [31:0] result_z;
		logic               saturated;
	} rsp_t;

	// quarter wave sine in unsigned Q0.15 from a Q30 taylor series, truncated products
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] x61;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x61 = HALF_PI_STEP * 64'(i) + (HALF_PI_REM * 64'(i)) / SINE_TABLE_DEPTH;
			x = x61 >> 31;
			x2 = (x * x) >> 30;
			t = x;
			sum = signed'(x);
			for (int n = 1; n <= 12; n++) begin
				t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if ((n % 2) == 1) begin
					sum = sum - signed'(t);
				end else begin
					sum = sum + signed'(t);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = (sum + 64'sd16384) >>> 15;
			if (v > 64'sd32767) begin
				v = 64'sd32767;
			end
			rom[i] = SIN_W'(v);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ----- hw/rtl/ert_if.sv -----
// request and result stream interfaces of the euler point transform
`default_nettype none

interface ert_req_if;
	logic          valid;
	logic          ready;
	ert_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ert_rsp_if;
	logic          valid;
	logic          ready;
	ert_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/euler_rotate_translate_point.sv -----
// Euler rotate-and-translate of a Q16.16 point: Rx*Ry*Rz, offset add, saturation.
// A 12-stage pipeline lies between request accept and result valid.
// Throughput: one request per cycle while rsp.ready is high; each stage holds at most one request and
// stalls independently, so bubbles close up while the result waits.
// Reset clears the stage valid bits only; the sine rom is constant.
`default_nettype none

module euler_rotate_translate_point (
	input  wire         clk,
	input  wire         arst_n,
	ert_req_if.sink     req,
	ert_rsp_if.source   rsp
);

	localparam int N = ert_pkg::NUM_STAGES;
	localparam int L = ert_pkg::NUM_LANES;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
	} crd_t;

	// stage control
	logic [N:1]   stage_vld_q;
	logic [N+1:1] stage_en;

	// payload registers
	crd_t crd_s1, crd_s2, crd_s3, crd_s4, crd_s5, crd_s6;
	crd_t crd_s7, crd_s8, crd_s9, crd_s10, crd_s11;
	logic signed [ert_pkg::ANG_W-1:0] ang_s1 [L];
	logic [ert_pkg::RED_W-1:0]        red_s2 [L];
	logic [ert_pkg::U_W-1:0]          u_s3 [L];
	logic [L-1:0]                     neg_s3, neg_s4, neg_s5, neg_s6;
	logic [ert_pkg::NUM_W-1:0]        num_s4 [L];
	logic [ert_pkg::IDX_W-1:0]        idx_s5 [L];
	logic [ert_pkg::SIN_W-1:0]        raw_s6 [L];
	logic signed [31:0] c2c3_s7, c2s3_s7, s1s2_s7, c1s3_s7, c1c3_s7;
	logic signed [31:0] s1c2_s7, s1s3_s7, c1s2_s7, s1c3_s7, c1c2_s7;
	logic signed [15:0] s2_s7, c3_s7, s3_s7;
	logic signed [31:0] c2c3_s8, c2s3_s8, c1s3_s8, c1c3_s8;
	logic signed [31:0] s1c2_s8, s1s3_s8, s1c3_s8, c1c2_s8;
	logic signed [15:0] s2_s8;
	logic signed [47:0] s1s2c3_s8, s1s2s3_s8, c1s2c3_s8, c1s2s3_s8;
	logic signed [ert_pkg::MAT_W-1:0] m_s9 [9];
	logic signed [ert_pkg::MUL_W-1:0] prod_s10 [9];
	logic signed [ert_pkg::ROW_W-1:0] row_s11 [3];
	logic signed [31:0] res_s12 [3];
	logic               sat_s12;

	// combinational stage inputs
	logic signed [ert_pkg::ANG_W-1:0] ang_in [L];
	logic [ert_pkg::RED_W-1:0]        red_in [L];
	logic [ert_pkg::U_W-1:0]          u_in [L];
	logic [L-1:0]                     neg_in;
	logic [ert_pkg::IDX_W-1:0]        idx_in [L];
	logic signed [15:0]               val [L];
	logic signed [ert_pkg::ENT_W-1:0] ent [9];
	logic signed [31:0]               pcol [3];
	logic signed [ert_pkg::ROW_W-1:0] row_in [3];
	logic signed [31:0]               res_in [3];
	logic [2:0]                       sat_in;
	logic signed [31:0]               off_s11 [3];

	// ready chain: a stage moves when it is empty or its successor moves
	assign stage_en[N+1] = rsp.ready;
	for (genvar k = 1; k <= N; k++) begin : g_en
		assign stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
	end

	assign req.ready = stage_en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[1]) begin
				stage_vld_q[1] <= req.valid;
			end
			for (int k = 2; k <= N; k++) begin
				if (stage_en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	// angle lanes: sine at a, cosine at a plus a quarter turn
	always_comb begin
		ang_in[0] = ert_pkg::ANG_W'(req.data.angle_about_x);
		ang_in[1] = ert_pkg::ANG_W'(req.data.angle_about_x) + ert_pkg::ANG_W'(ert_pkg::QUARTER_TURN);
		ang_in[2] = ert_pkg::ANG_W'(req.data.angle_about_y);
		ang_in[3] = ert_pkg::ANG_W'(req.data.angle_about_y) + ert_pkg::ANG_W'(ert_pkg::QUARTER_TURN);
		ang_in[4] = ert_pkg::ANG_W'(req.data.angle_about_z);
		ang_in[5] = ert_pkg::ANG_W'(req.data.angle_about_z) + ert_pkg::ANG_W'(ert_pkg::QUARTER_TURN);
	end

	// s1: capture request
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			crd_s1 <= '{req.data.point_x, req.data.point_y, req.data.point_z,
				req.data.offset_x, req.data.offset_y, req.data.offset_z};
			for (int l = 0; l < L; l++) begin
				ang_s1[l] <= ang_in[l];
			end
		end
	end

	// s2: reduce modulo a full turn after biasing positive
	always_comb begin
		logic [17:0] b;
		b = '0;
		for (int l = 0; l < L; l++) begin
			b = 18'(18'(ang_s1[l]) + 18'(2 * ert_pkg::FULL_TURN));
			if (b >= 18'(3 * ert_pkg::FULL_TURN)) begin
				red_in[l] = ert_pkg::RED_W'(b - 18'(3 * ert_pkg::FULL_TURN));
			end else if (b >= 18'(2 * ert_pkg::FULL_TURN)) begin
				red_in[l] = ert_pkg::RED_W'(b - 18'(2 * ert_pkg::FULL_TURN));
			end else if (b >= 18'(ert_pkg::FULL_TURN)) begin
				red_in[l] = ert_pkg::RED_W'(b - 18'(ert_pkg::FULL_TURN));
			end else begin
				red_in[l] = ert_pkg::RED_W'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			crd_s2 <= crd_s1;
			for (int l = 0; l < L; l++) begin
				red_s2[l] <= red_in[l];
			end
		end
	end

	// s3: quadrant fold into a quarter wave offset and a sign
	always_comb begin
		for (int l = 0; l < L; l++) begin
			if (red_s2[l] >= ert_pkg::RED_W'(ert_pkg::THREE_QUARTER)) begin
				u_in[l] = ert_pkg::U_W'(ert_pkg::FULL_TURN - int'(red_s2[l]));
				neg_in[l] = 1'b1;
			end else if (red_s2[l] >= ert_pkg::RED_W'(ert_pkg::HALF_TURN)) begin
				u_in[l] = ert_pkg::U_W'(red_s2[l] - ert_pkg::RED_W'(ert_pkg::HALF_TURN));
				neg_in[l] = 1'b1;
			end else if (red_s2[l] >= ert_pkg::RED_W'(ert_pkg::QUARTER_TURN)) begin
				u_in[l] = ert_pkg::U_W'(ert_pkg::HALF_TURN - int'(red_s2[l]));
				neg_in[l] = 1'b0;
			end else begin
				u_in[l] = ert_pkg::U_W'(red_s2[l]);
				neg_in[l] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			crd_s3 <= crd_s2;
			neg_s3 <= neg_in;
			for (int l = 0; l < L; l++) begin
				u_s3[l] <= u_in[l];
			end
		end
	end

	// s4: scaled index numerator with round to nearest
	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			crd_s4 <= crd_s3;
			neg_s4 <= neg_s3;
			for (int l = 0; l < L; l++) begin
				num_s4[l] <= ert_pkg::NUM_W'(ert_pkg::NUM_W'(u_s3[l])
					* ert_pkg::NUM_W'(ert_pkg::SINE_TABLE_DEPTH)
					+ ert_pkg::NUM_W'(ert_pkg::HALF_QUARTER));
			end
		end
	end

	// s5: divide by the quarter turn as shift then reciprocal multiply
	always_comb begin
		logic [ert_pkg::PRD_W-1:0]  p;
		logic [ert_pkg::QDIV_W-1:0] quo;
		p = '0;
		quo = '0;
		for (int l = 0; l < L; l++) begin
			p = ert_pkg::PRD_W'(num_s4[l] >> ert_pkg::QUARTER_SHIFT)
				* ert_pkg::PRD_W'(ert_pkg::IDX_RECIP);
			quo = ert_pkg::QDIV_W'(p >> 32);
			if (quo > ert_pkg::QDIV_W'(ert_pkg::SINE_TABLE_DEPTH)) begin
				idx_in[l] = ert_pkg::IDX_W'(ert_pkg::SINE_TABLE_DEPTH);
			end else begin
				idx_in[l] = ert_pkg::IDX_W'(quo);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			crd_s5 <= crd_s4;
			neg_s5 <= neg_s4;
			for (int l = 0; l < L; l++) begin
				idx_s5[l] <= idx_in[l];
			end
		end
	end

	// s6: rom read, one copy per axis with a sine and a cosine port
	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			crd_s6 <= crd_s5;
			neg_s6 <= neg_s5;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_rom
		always_ff @(posedge clk) begin
			if (stage_en[6]) begin
				raw_s6[2*a]   <= ert_pkg::SINE_ROM[idx_s5[2*a]];
				raw_s6[2*a+1] <= ert_pkg::SINE_ROM[idx_s5[2*a+1]];
			end
		end
	end

	// s7: apply sign, pairwise products
	always_comb begin
		for (int l = 0; l < L; l++) begin
			val[l] = neg_s6[l] ? -signed'(16'(raw_s6[l])) : signed'(16'(raw_s6[l]));
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			crd_s7  <= crd_s6;
			c2c3_s7 <= val[3] * val[5];
			c2s3_s7 <= val[3] * val[4];
			s1s2_s7 <= val[0] * val[2];
			c1s3_s7 <= val[1] * val[4];
			c1c3_s7 <= val[1] * val[5];
			s1c2_s7 <= val[0] * val[3];
			s1s3_s7 <= val[0] * val[4];
			c1s2_s7 <= val[1] * val[2];
			s1c3_s7 <= val[0] * val[5];
			c1c2_s7 <= val[1] * val[3];
			s2_s7   <= val[2];
			c3_s7   <= val[5];
			s3_s7   <= val[4];
		end
	end

	// s8: triple products
	always_ff @(posedge clk) begin
		if (stage_en[8]) begin
			crd_s8    <= crd_s7;
			c2c3_s8   <= c2c3_s7;
			c2s3_s8   <= c2s3_s7;
			c1s3_s8   <= c1s3_s7;
			c1c3_s8   <= c1c3_s7;
			s1c2_s8   <= s1c2_s7;
			s1s3_s8   <= s1s3_s7;
			s1c3_s8   <= s1c3_s7;
			c1c2_s8   <= c1c2_s7;
			s2_s8     <= s2_s7;
			s1s2c3_s8 <= s1s2_s7 * c3_s7;
			s1s2s3_s8 <= s1s2_s7 * s3_s7;
			c1s2c3_s8 <= c1s2_s7 * c3_s7;
			c1s2s3_s8 <= c1s2_s7 * s3_s7;
		end
	end

	// s9: matrix entries in Q45, rounded to Q30
	always_comb begin
		ent[0] = ert_pkg::ENT_W'(c2c3_s8) <<< 15;
		ent[1] = -(ert_pkg::ENT_W'(c2s3_s8) <<< 15);
		ent[2] = ert_pkg::ENT_W'(s2_s8) <<< 30;
		ent[3] = (ert_pkg::ENT_W'(c1s3_s8) <<< 15) + ert_pkg::ENT_W'(s1s2c3_s8);
		ent[4] = (ert_pkg::ENT_W'(c1c3_s8) <<< 15) - ert_pkg::ENT_W'(s1s2s3_s8);
		ent[5] = -(ert_pkg::ENT_W'(s1c2_s8) <<< 15);
		ent[6] = (ert_pkg::ENT_W'(s1s3_s8) <<< 15) - ert_pkg::ENT_W'(c1s2c3_s8);
		ent[7] = (ert_pkg::ENT_W'(s1c3_s8) <<< 15) + ert_pkg::ENT_W'(c1s2s3_s8);
		ent[8] = ert_pkg::ENT_W'(c1c2_s8) <<< 15;
	end

	always_ff @(posedge clk) begin
		if (stage_en[9]) begin
			crd_s9 <= crd_s8;
			for (int e = 0; e < 9; e++) begin
				m_s9[e] <= ert_pkg::MAT_W'((ent[e] + ert_pkg::ENT_W'(16384)) >>> 15);
			end
		end
	end

	// s10: entry times point coordinate
	always_comb begin
		pcol[0] = crd_s9.px;
		pcol[1] = crd_s9.py;
		pcol[2] = crd_s9.pz;
	end

	always_ff @(posedge clk) begin
		if (stage_en[10]) begin
			crd_s10 <= crd_s9;
			for (int e = 0; e < 9; e++) begin
				prod_s10[e] <= ert_pkg::MUL_W'(m_s9[e]) * ert_pkg::MUL_W'(pcol[e % 3]);
			end
		end
	end

	// s11: row sums rounded from Q46 to Q16
	always_comb begin
		logic signed [ert_pkg::SUM_W-1:0] s;
		s = '0;
		for (int r = 0; r < 3; r++) begin
			s = ert_pkg::SUM_W'(prod_s10[3*r]) + ert_pkg::SUM_W'(prod_s10[3*r+1])
				+ ert_pkg::SUM_W'(prod_s10[3*r+2]) + ert_pkg::SUM_W'(64'sd536870912);
			row_in[r] = ert_pkg::ROW_W'(s >>> 30);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[11]) begin
			crd_s11 <= crd_s10;
			for (int r = 0; r < 3; r++) begin
				row_s11[r] <= row_in[r];
			end
		end
	end

	// s12: offset add and saturation
	always_comb begin
		logic signed [ert_pkg::OUT_W-1:0] t;
		t = '0;
		off_s11[0] = crd_s11.ox;
		off_s11[1] = crd_s11.oy;
		off_s11[2] = crd_s11.oz;
		for (int r = 0; r < 3; r++) begin
			t = ert_pkg::OUT_W'(row_s11[r]) + ert_pkg::OUT_W'(off_s11[r]);
			if (t > ert_pkg::OUT_W'(64'sd2147483647)) begin
				res_in[r] = 32'sh7FFFFFFF;
				sat_in[r] = 1'b1;
			end else if (t < ert_pkg::OUT_W'(-64'sd2147483648)) begin
				res_in[r] = 32'sh80000000;
				sat_in[r] = 1'b1;
			end else begin
				res_in[r] = 32'(t);
				sat_in[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[12]) begin
			for (int r = 0; r < 3; r++) begin
				res_s12[r] <= res_in[r];
			end
			sat_s12 <= |sat_in;
		end
	end

	assign rsp.valid = stage_vld_q[N];
	assign rsp.data  = '{res_s12[0], res_s12[1], res_s12[2], sat_s12};

`ifndef SYNTHESIS
	// input is held off only when every stage holds a request
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (stage_vld_q == '1))
		else $error("request stalled with an empty stage");

	// occupancy follows accepted requests and taken results
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(stage_vld_q) == $past($countones(stage_vld_q))
			+ $past(int'(req.valid && req.ready)) - $past(int'(rsp.valid && rsp.ready)))
		else $error("pipeline lost or duplicated a request");

	// a set saturation flag means some coordinate sits at a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.saturated |->
			(rsp.data.result_x == 32'sh7FFFFFFF || rsp.data.result_x == 32'sh80000000 ||
			 rsp.data.result_y == 32'sh7FFFFFFF || rsp.data.result_y == 32'sh80000000 ||
			 rsp.data.result_z == 32'sh7FFFFFFF || rsp.data.result_z == 32'sh80000000))
		else $error("saturation flag without a clipped coordinate");
`endif

endmodule

`default_nettype wire
